[sv/gradient_histogram_accumulate_macros.svh]
// Assertion macros for the gradient histogram accumulator.
`ifndef GRADIENT_HISTOGRAM_ACCUMULATE_MACROS_SVH
`define GRADIENT_HISTOGRAM_ACCUMULATE_MACROS_SVH
`ifndef ASSERT_OFF
`define GHA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define GHA_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define GHA_ASSERT(lbl, clk, rstn, prop)
`define GHA_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

[sv/gha_pkg.sv]
`default_nettype none
package gha_pkg;

  localparam int MAX_ROWS     = 4096;
  localparam int MAX_FEATURES = 16;
  localparam int MAX_BINS     = 256;
  localparam int MAX_NODES    = 8;

  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int FEAT_W     = $clog2(MAX_FEATURES);
  localparam int FEAT_CNT_W = $clog2(MAX_FEATURES + 1);
  localparam int BIN_W      = $clog2(MAX_BINS);
  localparam int BIN_CNT_W  = $clog2(MAX_BINS + 1);
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int BINV_W     = BIN_W + 1;

  localparam int BT_DEPTH = MAX_ROWS * MAX_FEATURES;
  localparam int GT_DEPTH = MAX_ROWS;
  localparam int HS_DEPTH = MAX_NODES * MAX_BINS;
  localparam int HS_AW    = NODE_W + BIN_W;

  localparam int VAL_W = 32;
  localparam int SUM_W = 48;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_FEATURES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS     = 1'd1;

  localparam logic [1:0] OP_LOAD_BIN  = 2'd0;
  localparam logic [1:0] OP_LOAD_GRAD = 2'd1;
  localparam logic [1:0] OP_ACCUM     = 2'd2;
  localparam logic [1:0] OP_READ      = 2'd3;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    sum_t grad;
    sum_t hess;
  } hist_entry_t;

  typedef struct packed {
    val_t grad;
    val_t hess;
  } grad_pair_t;

endpackage
`default_nettype wire

[sv/gha_ram.sv]
`default_nettype none
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[sv/gha_sat_add.sv]
`default_nettype none
module gha_sat_add (
  input  wire gha_pkg::hist_entry_t acc_i,
  input  wire gha_pkg::grad_pair_t  add_i,
  output gha_pkg::hist_entry_t      sum_o
);

  function automatic gha_pkg::sum_t sat_add(gha_pkg::sum_t a, gha_pkg::val_t b);
    logic signed [gha_pkg::SUM_W:0] s;
    gha_pkg::sum_t                  r;
    s = {a[gha_pkg::SUM_W-1], a} + (gha_pkg::SUM_W + 1)'(b);
    if (s[gha_pkg::SUM_W] != s[gha_pkg::SUM_W-1]) begin
      r = {s[gha_pkg::SUM_W], {(gha_pkg::SUM_W - 1){~s[gha_pkg::SUM_W]}}};
    end else begin
      r = s[gha_pkg::SUM_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    sum_o.grad = sat_add(acc_i.grad, add_i.grad);
    sum_o.hess = sat_add(acc_i.hess, add_i.hess);
  end

endmodule
`default_nettype wire

[sv/gradient_histogram_accumulate.sv]
// Channel  Direction  Handshake                    Payload
// in       input      in_valid_i / in_stall_o      operation .. hess_in
// out      output     out_valid_o / out_stall_i    grad_sum, hess_sum
// cfg      input      cfg_we_i (no wait)           cfg_idx_i, cfg_wdata_i
//
// A load writes its table directly, a read passes through a read-and-clear step, and
// an accumulate through a preparation step and one read-modify-write per feature.
// After reset a clearing pass zeroes all 2048 histogram entries; no
// transaction is taken on the input meanwhile, though configuration writes are.
// A waiting result stalls only a further read; other operations still proceed.
`default_nettype none
`include "gradient_histogram_accumulate_macros.svh"
module gradient_histogram_accumulate (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic [1:0]                             operation_i,
  input  wire logic [gha_pkg::NODE_W-1:0]             node_index_i,
  input  wire logic [gha_pkg::ROW_W-1:0]              row_index_i,
  input  wire logic [gha_pkg::FEAT_W-1:0]             feature_index_i,
  input  wire logic signed [gha_pkg::BINV_W-1:0]      bin_value_i,
  input  wire logic signed [gha_pkg::VAL_W-1:0]       grad_in_i,
  input  wire logic signed [gha_pkg::VAL_W-1:0]       hess_in_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic signed [gha_pkg::SUM_W-1:0]            grad_sum_o,
  output logic signed [gha_pkg::SUM_W-1:0]            hess_sum_o,
  input  wire logic                                   cfg_we_i,
  input  wire logic [gha_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire logic [gha_pkg::CFG_DATA_W-1:0]         cfg_wdata_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_RCLR = 3'd4;

  localparam int BT_AW = gha_pkg::ROW_W + gha_pkg::FEAT_W;

  logic [2:0] state_q, state_d;
  logic clr_q, clr_d;
  logic [gha_pkg::HS_AW-1:0] clr_addr_q, clr_addr_d;
  logic [gha_pkg::ROW_W-1:0] row_q, row_d;
  logic [gha_pkg::NODE_W-1:0] node_q, node_d;
  logic [gha_pkg::FEAT_W-1:0] feat_q, feat_d;
  logic [gha_pkg::HS_AW-1:0] slot_q, slot_d;
  logic skip_q, skip_d;
  logic neg_q, neg_d;
  logic out_valid_q, out_valid_d;
  gha_pkg::sum_t grad_sum_q, grad_sum_d, hess_sum_q, hess_sum_d;
  logic [gha_pkg::FEAT_CNT_W-1:0] cfg_feat_q;
  logic [gha_pkg::BIN_CNT_W-1:0] cfg_bins_q;

  logic [gha_pkg::FEAT_CNT_W-1:0] nf;
  logic [gha_pkg::BIN_CNT_W-1:0] nb;
  logic [gha_pkg::FEAT_CNT_W-1:0] feat_next;
  logic in_acc;

  logic bt_we, bt_re;
  logic [BT_AW-1:0] bt_waddr, bt_raddr;
  logic [gha_pkg::BINV_W-1:0] bt_rdata;
  logic gt_we, gt_re;
  gha_pkg::grad_pair_t gt_wdata, gt_rdata;
  logic hs_we, hs_re;
  logic [gha_pkg::HS_AW-1:0] hs_waddr, hs_raddr;
  gha_pkg::hist_entry_t hs_wdata, hs_rdata, sum_res;

  assign nf = (cfg_feat_q > gha_pkg::FEAT_CNT_W'(gha_pkg::MAX_FEATURES)) ?
              gha_pkg::FEAT_CNT_W'(gha_pkg::MAX_FEATURES) : cfg_feat_q;
  assign nb = (cfg_bins_q > gha_pkg::BIN_CNT_W'(gha_pkg::MAX_BINS)) ?
              gha_pkg::BIN_CNT_W'(gha_pkg::MAX_BINS) : cfg_bins_q;
  assign feat_next = gha_pkg::FEAT_CNT_W'(feat_q) + 1'b1;

  assign in_stall_o = (state_q != S_IDLE) || clr_q ||
                      (out_valid_q && (operation_i == gha_pkg::OP_READ));
  assign in_acc = in_valid_i && !in_stall_o;

  assign bt_we    = in_acc && (operation_i == gha_pkg::OP_LOAD_BIN);
  assign bt_waddr = {row_index_i, feature_index_i};
  assign bt_re    = (state_q == S_PREP) || (state_q == S_WR);
  assign bt_raddr = (state_q == S_PREP) ? {row_q, gha_pkg::FEAT_W'(0)} :
                    {row_q, feat_next[gha_pkg::FEAT_W-1:0]};

  assign gt_we         = in_acc && (operation_i == gha_pkg::OP_LOAD_GRAD);
  assign gt_wdata.grad = grad_in_i;
  assign gt_wdata.hess = hess_in_i;
  assign gt_re         = (state_q == S_PREP);

  assign hs_re    = (state_q == S_RD) || (in_acc && (operation_i == gha_pkg::OP_READ));
  assign hs_raddr = (state_q == S_RD) ? {node_q, bt_rdata[gha_pkg::BIN_W-1:0]} :
                    {node_index_i, bin_value_i[gha_pkg::BIN_W-1:0]};

  always_comb begin
    hs_we    = 1'b0;
    hs_waddr = slot_q;
    hs_wdata = '0;
    if (clr_q) begin
      hs_we    = 1'b1;
      hs_waddr = clr_addr_q;
    end else if (state_q == S_WR) begin
      hs_we    = !skip_q;
      hs_wdata = sum_res;
    end else if (state_q == S_RCLR) begin
      hs_we    = !neg_q;
    end
  end

  gha_ram #(.WIDTH(gha_pkg::BINV_W), .DEPTH(gha_pkg::BT_DEPTH)) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (bt_we),
    .waddr_i (bt_waddr),
    .wdata_i (bin_value_i),
    .re_i    (bt_re),
    .raddr_i (bt_raddr),
    .rdata_o (bt_rdata)
  );

  gha_ram #(.WIDTH(2 * gha_pkg::VAL_W), .DEPTH(gha_pkg::GT_DEPTH)) u_grad_ram (
    .clk_i   (clk_i),
    .we_i    (gt_we),
    .waddr_i (row_index_i),
    .wdata_i (gt_wdata),
    .re_i    (gt_re),
    .raddr_i (row_q),
    .rdata_o (gt_rdata)
  );

  gha_ram #(.WIDTH(2 * gha_pkg::SUM_W), .DEPTH(gha_pkg::HS_DEPTH)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hs_we),
    .waddr_i (hs_waddr),
    .wdata_i (hs_wdata),
    .re_i    (hs_re),
    .raddr_i (hs_raddr),
    .rdata_o (hs_rdata)
  );

  gha_sat_add u_sat_add (
    .acc_i (hs_rdata),
    .add_i (gt_rdata),
    .sum_o (sum_res)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    clr_addr_d  = clr_addr_q;
    row_d       = row_q;
    node_d      = node_q;
    feat_d      = feat_q;
    slot_d      = slot_q;
    skip_d      = skip_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && out_stall_i;
    grad_sum_d  = grad_sum_q;
    hess_sum_d  = hess_sum_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == {gha_pkg::HS_AW{1'b1}}) begin
        clr_d = 1'b0;
      end
    end
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          row_d  = row_index_i;
          node_d = node_index_i;
          slot_d = {node_index_i, bin_value_i[gha_pkg::BIN_W-1:0]};
          neg_d  = bin_value_i[gha_pkg::BINV_W-1];
          if (operation_i == gha_pkg::OP_ACCUM) begin
            state_d = S_PREP;
          end else if (operation_i == gha_pkg::OP_READ) begin
            state_d = S_RCLR;
          end
        end
      end
      S_PREP: begin
        feat_d  = '0;
        state_d = (nf == '0) ? S_IDLE : S_RD;
      end
      S_RD: begin
        slot_d  = {node_q, bt_rdata[gha_pkg::BIN_W-1:0]};
        skip_d  = bt_rdata[gha_pkg::BINV_W-1] ||
                  (gha_pkg::BIN_CNT_W'(bt_rdata[gha_pkg::BIN_W-1:0]) >= nb);
        state_d = S_WR;
      end
      S_WR: begin
        feat_d = feat_next[gha_pkg::FEAT_W-1:0];
        if (feat_next == nf) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_RD;
        end
      end
      S_RCLR: begin
        out_valid_d = 1'b1;
        grad_sum_d  = neg_q ? '0 : hs_rdata.grad;
        hess_sum_d  = neg_q ? '0 : hs_rdata.hess;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      clr_q       <= 1'b1;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
      cfg_feat_q  <= gha_pkg::FEAT_CNT_W'(gha_pkg::MAX_FEATURES);
      cfg_bins_q  <= gha_pkg::BIN_CNT_W'(gha_pkg::MAX_BINS);
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_idx_i == gha_pkg::CFG_FEATURES)) begin
        cfg_feat_q <= cfg_wdata_i[gha_pkg::FEAT_CNT_W-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == gha_pkg::CFG_BINS)) begin
        cfg_bins_q <= cfg_wdata_i[gha_pkg::BIN_CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_q      <= row_d;
    node_q     <= node_d;
    feat_q     <= feat_d;
    slot_q     <= slot_d;
    skip_q     <= skip_d;
    neg_q      <= neg_d;
    grad_sum_q <= grad_sum_d;
    hess_sum_q <= hess_sum_d;
  end

  assign out_valid_o = out_valid_q;
  assign grad_sum_o  = grad_sum_q;
  assign hess_sum_o  = hess_sum_q;

  // A transaction is taken only when idle and the clearing pass has finished.
  `GHA_ASSERT(a_accept_idle, clk_i, rst_ni, in_acc |-> (state_q == S_IDLE && !clr_q))
  // A result appears only after the read-and-clear step.
  `GHA_ASSERT(a_out_from_read, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q) == S_RCLR)
  // Outside the clearing pass the histogram is written only by the sequencer.
  `GHA_ASSERT(a_hist_write, clk_i, rst_ni,
    (hs_we && !clr_q) |-> (state_q == S_WR || state_q == S_RCLR))
  // The clearing pass is pending on the cycle after any reset cycle.
  `GHA_ASSERT_NORST(a_clear_in_reset, clk_i, !rst_ni |=> clr_q)

endmodule
`default_nettype wire
